// ===== src/ufr_pkg.sv =====
// shared types and constants for the serial frame receiver
// no dependencies; imported by ufr_frame_fsm and uart_frame_receiver

package ufr_pkg;

    // frame framing constants
    localparam logic [7:0] HEADER_BYTE    = 8'hEB;
    localparam logic [7:0] TAIL_MIN_COUNT = 8'd7;
    localparam logic [8:0] LENGTH_OFFSET  = 9'd3;
    localparam logic [7:0] MAX_DATA_COUNT = 8'd80;
    localparam logic [7:0] BUF_DEPTH      = 8'd128;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned TAIL_W   = 32;
    localparam int unsigned RECENT_W = 24;
    localparam int unsigned M_DATA_W = 24;

    // configuration register indexes
    localparam logic CFG_TAIL_PATTERN  = 1'b0;
    localparam logic CFG_FEEDBACK_CODE = 1'b1;

    // frame phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_LENGTH  = 6'b000010,
        PH_ADDRESS = 6'b000100,
        PH_COMMAND = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_TAIL    = 6'b100000
    } phase_t;

    // result of one received byte
    typedef struct packed {
        logic                 store_valid;
        logic [INDEX_W-1:0]   store_index;
        logic [BYTE_W-1:0]    store_data;
        logic                 frame_done;
        logic                 ack_seen;
        logic                 frame_dropped;
    } result_t;

endpackage

// ===== src/ufr_frame_fsm.sv =====
// frame phase tracker: holds phase, count, length and recent bytes
// and computes the result of each received byte; uses ufr_pkg

module ufr_frame_fsm import ufr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_xfer,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic [TAIL_W-1:0]    tail_pattern,
    input  logic [BYTE_W-1:0]    feedback_code,
    output result_t              result
);

    phase_t                phase_reg, phase_next;
    logic [INDEX_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]     length_reg, length_next;
    logic [RECENT_W-1:0]   recent_reg, recent_next;

    logic [7:0]            count_inc;
    logic                  keep;
    logic [INDEX_W-1:0]    idx;
    logic                  done, ack, drop;

    assign count_inc = {1'b0, count_reg} + 8'd1;

    // next state and result for the byte on rx_byte
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        keep        = 1'b0;
        idx         = '0;
        done        = 1'b0;
        ack         = 1'b0;
        drop        = 1'b0;
        unique case (phase_reg)
            PH_HEADER: begin
                if (rx_byte == HEADER_BYTE) begin
                    keep       = 1'b1;
                    idx        = '0;
                    count_next = 7'd1;
                end else if (count_reg == 7'd1) begin
                    keep       = 1'b1;
                    idx        = 7'd1;
                    count_next = 7'd2;
                    phase_next = PH_LENGTH;
                end else begin
                    count_next = '0;
                end
            end
            PH_LENGTH: begin
                keep        = 1'b1;
                idx         = count_reg;
                count_next  = count_inc[INDEX_W-1:0];
                length_next = rx_byte;
                if (rx_byte == feedback_code) begin
                    ack        = 1'b1;
                    phase_next = PH_TAIL;
                end else begin
                    phase_next = PH_ADDRESS;
                end
            end
            PH_ADDRESS: begin
                keep       = 1'b1;
                idx        = count_reg;
                count_next = count_inc[INDEX_W-1:0];
                phase_next = PH_COMMAND;
            end
            PH_COMMAND: begin
                keep       = 1'b1;
                idx        = count_reg;
                count_next = count_inc[INDEX_W-1:0];
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                keep = 1'b1;
                idx  = count_reg;
                if (count_inc < MAX_DATA_COUNT) begin
                    count_next = count_inc[INDEX_W-1:0];
                    if (({1'b0, count_inc} + LENGTH_OFFSET) == {1'b0, length_reg}) begin
                        phase_next = PH_TAIL;
                    end
                end else begin
                    drop       = 1'b1;
                    count_next = '0;
                    phase_next = PH_HEADER;
                end
            end
            PH_TAIL: begin
                keep = 1'b1;
                idx  = count_reg;
                if (count_inc >= TAIL_MIN_COUNT && {recent_reg, rx_byte} == tail_pattern) begin
                    done       = 1'b1;
                    count_next = '0;
                    phase_next = PH_HEADER;
                end else if (count_inc >= BUF_DEPTH) begin
                    drop       = 1'b1;
                    count_next = '0;
                    phase_next = PH_HEADER;
                end else begin
                    count_next = count_inc[INDEX_W-1:0];
                end
            end
            default: begin
                count_next = '0;
                phase_next = PH_HEADER;
            end
        endcase
    end

    // history of kept bytes for the tail match
    assign recent_next = keep ? {recent_reg[RECENT_W-BYTE_W-1:0], rx_byte} : recent_reg;

    // result fields are zero for a discarded byte
    always_comb begin
        result.store_valid   = keep;
        result.store_index   = keep ? idx : '0;
        result.store_data    = keep ? rx_byte : '0;
        result.frame_done    = done;
        result.ack_seen      = ack;
        result.frame_dropped = drop;
    end

    // state update on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            length_reg <= '0;
            recent_reg <= '0;
        end else if (byte_xfer) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            recent_reg <= recent_next;
        end
    end

endmodule

// ===== src/uart_frame_receiver.sv =====
// top level of the serial frame receiver: config registers, result register
// depends on ufr_pkg and ufr_frame_fsm
//
// usage:
//   s_ channel carries one received byte per transfer in s_tdata.
//   every accepted byte produces exactly one result on the m_ channel: whether
//   the byte was kept, its index in the frame, the byte itself, and flags for
//   acknowledge length and dropped frame; m_tlast marks the byte that
//   completed the tail pattern. tail_pattern (index 0) and feedback_code (index 1)
//   are written through cfg_we / cfg_index / cfg_wdata; the user must write them only
//   while no byte is in flight, and the block itself does not enforce it.
// timing:
//   m_tvalid is registered and is set in the cycle after the input transfer; one byte
//   per cycle is sustained while m_tready is high, set by the one result register.
// reset:
//   aresetn low clears the phase to header hunt, the count, the history,
//   both config registers and the result register valid.
// stall:
//   while a result waits and m_tready is low, s_tready is low; the byte
//   is taken in the same cycle the pending result leaves.

module uart_frame_receiver import ufr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] store_valid, [7:1] store_index,
                                            // [15:8] store_data, [16] ack_seen,
                                            // [17] frame_dropped, [23:18] zero
    output logic                 m_tlast,   // frame_done
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [TAIL_W-1:0]    cfg_wdata
);

    logic [TAIL_W-1:0]  tail_pattern_reg;
    logic [BYTE_W-1:0]  feedback_code_reg;
    logic               s_xfer;
    result_t            step_result;
    result_t            result_reg;
    logic               m_valid_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_pattern_reg  <= '0;
            feedback_code_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TAIL_PATTERN:  tail_pattern_reg  <= cfg_wdata;
                CFG_FEEDBACK_CODE: feedback_code_reg <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    ufr_frame_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_xfer     (s_xfer),
        .rx_byte       (s_tdata),
        .tail_pattern  (tail_pattern_reg),
        .feedback_code (feedback_code_reg),
        .result        (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= step_result;
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = result_reg.frame_done;
    assign m_tdata  = {6'd0,
                       result_reg.frame_dropped,
                       result_reg.ack_seen,
                       result_reg.store_data,
                       result_reg.store_index,
                       result_reg.store_valid};

    // checks
    a_done_not_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.frame_done && result_reg.frame_dropped))
        else $error("frame completed and dropped on the same byte");

    a_ack_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.ack_seen) |->
            (result_reg.store_valid && result_reg.store_index == 7'd2))
        else $error("acknowledge flagged away from the length byte");

    a_discard_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !result_reg.store_valid) |->
            (result_reg.store_index == '0 && result_reg.store_data == '0 &&
             !result_reg.frame_done && !result_reg.frame_dropped))
        else $error("discarded byte carries nonzero result fields");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid_reg)
        else $error("accepted byte produced no result");

endmodule

// ===== verif/uart_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for uart_frame_receiver: directed byte table, then random frames
// depends on ufr_pkg and the receiver rtl; predicts every result transfer and compares fields

module uart_frame_receiver_tb import ufr_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned NUM_SEGMENTS = 8;
    localparam int unsigned SEG_ITEMS    = 150;
    localparam int unsigned DIR_ROWS     = 21;

    // one directed row: byte, whether the result is typed in, typed result
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    res;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        {8'h00, 1'b1, {1'b0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0}},  // discarded in hunt
        {8'hFF, 1'b1, {1'b0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0}},  // discarded in hunt
        {8'hEB, 1'b1, {1'b1, 7'd0, 8'hEB, 1'b0, 1'b0, 1'b0}},  // header
        {8'hEB, 1'b1, {1'b1, 7'd0, 8'hEB, 1'b0, 1'b0, 1'b0}},  // header restarts
        {8'h12, 1'b0, 19'd0},                                  // second byte
        {8'h0A, 1'b0, 19'd0},                                  // length 10
        {8'h33, 1'b0, 19'd0},                                  // address
        {8'h44, 1'b0, 19'd0},                                  // command
        {8'h55, 1'b0, 19'd0},                                  // data
        {8'h66, 1'b0, 19'd0},                                  // last data
        {8'hA1, 1'b0, 19'd0},
        {8'hB2, 1'b0, 19'd0},
        {8'hC3, 1'b0, 19'd0},
        {8'hD4, 1'b1, {1'b1, 7'd10, 8'hD4, 1'b1, 1'b0, 1'b0}}, // tail completes
        {8'hEB, 1'b1, {1'b1, 7'd0, 8'hEB, 1'b0, 1'b0, 1'b0}},
        {8'h00, 1'b0, 19'd0},
        {8'h06, 1'b1, {1'b1, 7'd2, 8'h06, 1'b0, 1'b1, 1'b0}},  // acknowledge length
        {8'hA1, 1'b0, 19'd0},
        {8'hB2, 1'b0, 19'd0},
        {8'hC3, 1'b0, 19'd0},
        {8'hD4, 1'b1, {1'b1, 7'd6, 8'hD4, 1'b1, 1'b0, 1'b0}}   // short frame done
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    // predictor state and register copies
    phase_t      fr_phase;
    logic [6:0]  fr_count;
    logic [7:0]  fr_length;
    logic [23:0] fr_recent;
    logic [31:0] tail_pat;
    logic [7:0]  fb_code;

    result_t     result_q [$];
    logic [7:0]  rx_plan [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned kept_cnt;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;

    uart_frame_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // frame assembly for one received byte
    function automatic result_t assemble_byte(input logic [7:0] rx);
        result_t     r;
        int unsigned nxt;
        r = '0;
        nxt = fr_count + 1;
        case (fr_phase)
            PH_HEADER: begin
                if (rx == HEADER_BYTE) begin
                    r.store_valid = 1'b1;
                    r.store_index = 7'd0;
                    fr_count = 7'd1;
                end else if (fr_count == 7'd1) begin
                    r.store_valid = 1'b1;
                    r.store_index = 7'd1;
                    fr_count = 7'd2;
                    fr_phase = PH_LENGTH;
                end else begin
                    fr_count = 7'd0;
                end
            end
            PH_LENGTH: begin
                r.store_valid = 1'b1;
                r.store_index = fr_count;
                fr_count = fr_count + 7'd1;
                fr_length = rx;
                if (rx == fb_code) begin
                    r.ack_seen = 1'b1;
                    fr_phase = PH_TAIL;
                end else begin
                    fr_phase = PH_ADDRESS;
                end
            end
            PH_ADDRESS, PH_COMMAND: begin
                r.store_valid = 1'b1;
                r.store_index = fr_count;
                fr_count = fr_count + 7'd1;
                fr_phase = (fr_phase == PH_ADDRESS) ? PH_COMMAND : PH_DATA;
            end
            PH_DATA: begin
                r.store_valid = 1'b1;
                r.store_index = fr_count;
                if (nxt < MAX_DATA_COUNT) begin
                    fr_count = nxt[6:0];
                    if (nxt + LENGTH_OFFSET == fr_length)
                        fr_phase = PH_TAIL;
                end else begin
                    r.frame_dropped = 1'b1;
                    fr_count = 7'd0;
                    fr_phase = PH_HEADER;
                end
            end
            PH_TAIL: begin
                r.store_valid = 1'b1;
                r.store_index = fr_count;
                if (nxt >= TAIL_MIN_COUNT && {fr_recent, rx} == tail_pat) begin
                    r.frame_done = 1'b1;
                    fr_count = 7'd0;
                    fr_phase = PH_HEADER;
                end else if (nxt >= BUF_DEPTH) begin
                    r.frame_dropped = 1'b1;
                    fr_count = 7'd0;
                    fr_phase = PH_HEADER;
                end else begin
                    fr_count = nxt[6:0];
                end
            end
            default: begin
                fr_count = 7'd0;
                fr_phase = PH_HEADER;
            end
        endcase
        if (r.store_valid) begin
            r.store_data = rx;
            fr_recent = {fr_recent[15:0], rx};
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // one byte transfer on the input side, with optional idle cycles first
    task automatic send_byte(input logic [7:0] rx, input logic typed, input result_t typed_res);
        result_t pred;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        pred = assemble_byte(rx);
        result_q.push_back(typed ? typed_res : pred);
        if (pred.store_valid)
            kept_cnt++;
    endtask

    // both registers, one after the other
    task automatic write_regs(input logic [31:0] tail, input logic [7:0] code);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAIL_PATTERN;
        cfg_wdata <= tail;
        @(posedge aclk);
        cfg_index <= CFG_FEEDBACK_CODE;
        cfg_wdata <= {24'd0, code};
        @(posedge aclk);
        cfg_we <= 1'b0;
        tail_pat = tail;
        fb_code  = code;
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one frame, a broken frame or line noise into rx_plan
    task automatic plan_frame();
        int unsigned kind;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  len;
        kind = $urandom_range(99);
        // noise, with an occasional header byte
        if (kind < 12) begin
            n = $urandom_range(6, 1);
            repeat (n) rx_plan.push_back(($urandom_range(9) == 0) ? HEADER_BYTE : 8'($urandom));
            return;
        end
        rx_plan.push_back(HEADER_BYTE);
        rx_plan.push_back(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 15)
            len = fb_code;
        else if (pick < 27)
            len = ($urandom_range(1) == 0) ? 8'($urandom_range(8)) : 8'($urandom_range(255, 83));
        else if ($urandom_range(3) == 0)
            len = 8'($urandom_range(82, 9));
        else
            len = 8'($urandom_range(20, 9));
        rx_plan.push_back(len);
        if (len != fb_code) begin
            rx_plan.push_back(8'($urandom));
            rx_plan.push_back(8'($urandom));
            // an unreachable length runs into the data limit
            n = (len >= 9 && len <= 82) ? len - 8 : MAX_DATA_COUNT - 5;
            repeat (n) rx_plan.push_back(8'($urandom));
            if (n == MAX_DATA_COUNT - 5)
                return;
        end
        // tail: mostly the pattern, sometimes late, rarely never (tail limit)
        pick = $urandom_range(99);
        if (pick < 5) begin
            repeat (130) rx_plan.push_back(8'($urandom));
        end else begin
            if (pick < 25) begin
                n = $urandom_range(4, 1);
                repeat (n) rx_plan.push_back(8'($urandom));
            end
            rx_plan.push_back(tail_pat[31:24]);
            rx_plan.push_back(tail_pat[23:16]);
            rx_plan.push_back(tail_pat[15:8]);
            rx_plan.push_back(tail_pat[7:0]);
        end
        // broken frame: cut short at a random point
        if (kind < 22) begin
            n = $urandom_range(rx_plan.size() - 1, 1);
            repeat (n) void'(rx_plan.pop_back());
        end
    endtask

    // result side: random stall and comparison against the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $error("result transfer with no expectation pending");
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                check_field("store_valid", want.store_valid, m_tdata[0]);
                check_field("store_index", want.store_index, m_tdata[7:1]);
                check_field("store_data", want.store_data, m_tdata[15:8]);
                check_field("ack_seen", want.ack_seen, m_tdata[16]);
                check_field("frame_dropped", want.frame_dropped, m_tdata[17]);
                check_field("tdata padding", 0, m_tdata[23:18]);
                check_field("frame_done", want.frame_done, m_tlast);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TAIL_PATTERN;
        cfg_wdata <= 32'd0;
        fr_phase  = PH_HEADER;
        fr_count  = 7'd0;
        fr_length = 8'd0;
        fr_recent = 24'd0;
        tail_pat  = 32'd0;
        fb_code   = 8'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        kept_cnt  = 0;
        fail_cnt  = 0;
        cycle_cnt = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        write_regs(32'hA1B2_C3D4, 8'h06);
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].typed, DIR_TABLE[i].res);
        s_tvalid <= 1'b0;

        // random frames, one register setting and idle pattern per segment
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            wait_drained();
            case (seg)
                0:       write_regs(32'hFFFF_FFFF, 8'hFF);
                1:       write_regs(32'h0000_0000, 8'h00);
                default: write_regs($urandom, 8'($urandom));
            endcase
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            kept_cnt = 0;
            while (kept_cnt < SEG_ITEMS) begin
                plan_frame();
                while (rx_plan.size() != 0)
                    send_byte(rx_plan.pop_front(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
